### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg
// Types, command and status codes, and sizes for the LIFO stack.
// ----------------------------------------------------------------------------
package stk_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_W     = 9;
    localparam int CMP_W       = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

    localparam logic [DATA_W-1:0] WORD_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] WORD_ONES = {DATA_W{1'b1}};

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_PEEK   = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_MAX    = 3'd4;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] operand_value;
        logic [DEPTH_W-1:0]       depth_index;
    } in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] result_value;
        logic [DEPTH_W-1:0]       found_depth;
        logic                     is_empty;
    } out_t;

endpackage

### rtl/stack_with_search_and_max.sv
// ----------------------------------------------------------------------------
// stack_with_search_and_max
// Bounded LIFO stack of signed words with push, pop, peek, search and max.
// ----------------------------------------------------------------------------
// One transaction is in work at a time. Push, a failed command and an unknown
// command go from acceptance to the FIN state and then to the output register;
// pop and peek pass through RD first (one registered read of the entry memory).
// Search and max stream the stored entries through the single memory read port,
// one per cycle, top first, search ending at the first match.
// The next transaction is accepted while a result waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stack_with_search_and_max (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  stk_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output stk_pkg::out_t  m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [stk_pkg::DATA_W-1:0] mem [stk_pkg::STACK_DEPTH];

    logic [1:0]                         state_reg, state_next;
    logic [stk_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic [2:0]                         op_reg, op_next;
    logic [stk_pkg::DATA_W-1:0]         key_reg, key_next;
    logic [stk_pkg::ADDR_W-1:0]         rd_addr_reg, rd_addr_next;
    logic [stk_pkg::CNT_W-1:0]          pos_reg, pos_next;
    logic signed [stk_pkg::DATA_W-1:0]  acc_reg, acc_next;
    stk_pkg::out_t                      res_reg, res_next;
    stk_pkg::out_t                      out_reg, out_next;
    logic                               m_valid_reg, m_valid_next;
    logic signed [stk_pkg::DATA_W-1:0]  rdata_reg;

    logic                               mem_we;
    logic [stk_pkg::ADDR_W-1:0]         mem_raddr;
    logic [stk_pkg::DEPTH_W-1:0]        peek_d;
    logic signed [stk_pkg::DATA_W-1:0]  acc_upd;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cnt_reg[stk_pkg::ADDR_W-1:0]] <= s_data.operand_value;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb begin
        peek_d  = (s_data.depth_index == '0) ? stk_pkg::DEPTH_W'(1) : s_data.depth_index;
        acc_upd = (rdata_reg > acc_reg) ? rdata_reg : acc_reg;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        rd_addr_next = rd_addr_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        mem_we       = 1'b0;
        mem_raddr    = rd_addr_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next  = s_data.cmd;
                    key_next = s_data.operand_value;
                    res_next = '{status: stk_pkg::STAT_OK, result_value: '0,
                                 found_depth: '0, is_empty: (cnt_reg == '0)};
                    state_next = ST_FIN;
                    case (s_data.cmd)
                        stk_pkg::CMD_PUSH: begin
                            if (cnt_reg == stk_pkg::CNT_W'(stk_pkg::STACK_DEPTH)) begin
                                res_next.status = stk_pkg::STAT_FULL;
                            end else begin
                                mem_we            = 1'b1;
                                cnt_next          = cnt_reg + 1'b1;
                                res_next.is_empty = 1'b0;
                            end
                        end
                        stk_pkg::CMD_POP: begin
                            if (cnt_reg == '0) begin
                                res_next.status       = stk_pkg::STAT_MISS;
                                res_next.result_value = stk_pkg::WORD_ONES;
                            end else begin
                                cnt_next          = cnt_reg - 1'b1;
                                mem_raddr         = stk_pkg::ADDR_W'(cnt_reg - 1'b1);
                                res_next.is_empty = (cnt_reg == stk_pkg::CNT_W'(1));
                                state_next        = ST_RD;
                            end
                        end
                        stk_pkg::CMD_PEEK: begin
                            if (stk_pkg::CMP_W'(peek_d) > stk_pkg::CMP_W'(cnt_reg)) begin
                                res_next.status       = stk_pkg::STAT_MISS;
                                res_next.result_value = stk_pkg::WORD_ONES;
                            end else begin
                                mem_raddr  = stk_pkg::ADDR_W'(stk_pkg::CMP_W'(cnt_reg)
                                             - stk_pkg::CMP_W'(peek_d));
                                state_next = ST_RD;
                            end
                        end
                        stk_pkg::CMD_SEARCH, stk_pkg::CMD_MAX: begin
                            if (cnt_reg == '0) begin
                                res_next.status = stk_pkg::STAT_MISS;
                                if (s_data.cmd == stk_pkg::CMD_MAX) begin
                                    res_next.result_value = stk_pkg::WORD_MIN;
                                end
                            end else begin
                                mem_raddr    = stk_pkg::ADDR_W'(cnt_reg - 1'b1);
                                rd_addr_next = stk_pkg::ADDR_W'(cnt_reg - 2'd2);
                                pos_next     = stk_pkg::CNT_W'(1);
                                acc_next     = stk_pkg::WORD_MIN;
                                state_next   = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RD: begin
                res_next.result_value = rdata_reg;
                state_next            = ST_FIN;
            end
            ST_SCAN: begin
                rd_addr_next = rd_addr_reg - 1'b1;
                pos_next     = pos_reg + 1'b1;
                acc_next     = acc_upd;
                if (op_reg == stk_pkg::CMD_SEARCH) begin
                    if (rdata_reg == key_reg) begin
                        res_next.found_depth = stk_pkg::DEPTH_W'(pos_reg);
                        state_next           = ST_FIN;
                    end else if (pos_reg == cnt_reg) begin
                        res_next.status = stk_pkg::STAT_MISS;
                        state_next      = ST_FIN;
                    end
                end else if (pos_reg == cnt_reg) begin
                    res_next.result_value = acc_upd;
                    state_next            = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg      <= op_next;
        key_reg     <= key_next;
        rd_addr_reg <= rd_addr_next;
        pos_reg     <= pos_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= stk_pkg::CNT_W'(stk_pkg::STACK_DEPTH), "count exceeds depth")
    `ASSERT_NEXT(a_push_inc, s_valid && s_ready && s_data.cmd == stk_pkg::CMD_PUSH && cnt_reg != stk_pkg::CNT_W'(stk_pkg::STACK_DEPTH), cnt_reg == $past(cnt_reg) + 1'b1, "push did not grow stack")
    `ASSERT_SAME(a_scan_pos, state_reg == ST_SCAN, cnt_reg != '0 && pos_reg <= cnt_reg, "scan past stored entries")
    `ASSERT_NEXT(a_fin_load, state_reg == ST_FIN && (!m_valid_reg || m_ready), m_valid_reg && state_reg == ST_IDLE, "result not loaded")

endmodule

### tb/stack_with_search_and_max_tb.sv
// ----------------------------------------------------------------------------
// stack_with_search_and_max_tb
// Self-checking regression for the bounded LIFO stack. A shadow stack
// predicts every result at input acceptance and a monitor compares each
// output transaction field by field. The run covers empty and full limits,
// word extremes, all commands including undefined codes, long random mixes,
// a long output hold-off that backs up the input, and a final stretch
// without idle cycles.
// ----------------------------------------------------------------------------
module stack_with_search_and_max_tb;

    localparam logic [2:0] CMD_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNDEF_LAST  = 3'd7;
    localparam logic signed [stk_pkg::DATA_W-1:0] WORD_MAX =
        {1'b0, {(stk_pkg::DATA_W-1){1'b1}}};
    localparam int LONG_HOLD   = 200;
    localparam int DRAIN_WAIT  = stk_pkg::STACK_DEPTH + 40;
    localparam int DEPTH_LIMIT = (1 << stk_pkg::DEPTH_W) - 1;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    stk_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    stk_pkg::out_t m_data;

    logic signed [stk_pkg::DATA_W-1:0] shadow_mem [stk_pkg::STACK_DEPTH];
    int            shadow_count  = 0;
    stk_pkg::out_t pending_results [$];
    stk_pkg::out_t oldest_result;
    int            mismatch_count = 0;
    bit            idle_on        = 1'b1;
    bit            hold_req       = 1'b0;
    int            rx_stall       = 0;

    stack_with_search_and_max dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic stk_pkg::out_t predict_stack_result(stk_pkg::in_t t);
        stk_pkg::out_t r;
        int unsigned d;
        int i;
        logic signed [stk_pkg::DATA_W-1:0] best;
        r = '0;
        r.status = stk_pkg::STAT_OK;
        case (t.cmd)
            stk_pkg::CMD_PUSH: begin
                if (shadow_count >= stk_pkg::STACK_DEPTH) begin
                    r.status = stk_pkg::STAT_FULL;
                end else begin
                    shadow_mem[shadow_count] = t.operand_value;
                    shadow_count++;
                end
            end
            stk_pkg::CMD_POP: begin
                if (shadow_count == 0) begin
                    r.status = stk_pkg::STAT_MISS;
                    r.result_value = stk_pkg::WORD_ONES;
                end else begin
                    shadow_count--;
                    r.result_value = shadow_mem[shadow_count];
                end
            end
            stk_pkg::CMD_PEEK: begin
                d = (t.depth_index == 0) ? 1 : t.depth_index;
                if (d > shadow_count) begin
                    r.status = stk_pkg::STAT_MISS;
                    r.result_value = stk_pkg::WORD_ONES;
                end else begin
                    r.result_value = shadow_mem[shadow_count - d];
                end
            end
            stk_pkg::CMD_SEARCH: begin
                r.status = stk_pkg::STAT_MISS;
                for (i = 0; i < shadow_count && r.status == stk_pkg::STAT_MISS; i++) begin
                    if (shadow_mem[shadow_count - 1 - i] == t.operand_value) begin
                        r.found_depth = stk_pkg::DEPTH_W'(i + 1);
                        r.status = stk_pkg::STAT_OK;
                    end
                end
            end
            stk_pkg::CMD_MAX: begin
                best = stk_pkg::WORD_MIN;
                if (shadow_count == 0)
                    r.status = stk_pkg::STAT_MISS;
                for (i = 0; i < shadow_count; i++) begin
                    if (shadow_mem[i] > best)
                        best = shadow_mem[i];
                end
                r.result_value = best;
            end
            default: ;
        endcase
        r.is_empty = (shadow_count == 0);
        return r;
    endfunction

    function automatic stk_pkg::in_t make_command(logic [2:0] cmd,
                                                  logic signed [stk_pkg::DATA_W-1:0] v,
                                                  logic [stk_pkg::DEPTH_W-1:0] d);
        stk_pkg::in_t t;
        t.cmd = cmd;
        t.operand_value = v;
        t.depth_index = d;
        return t;
    endfunction

    function automatic logic signed [stk_pkg::DATA_W-1:0] random_word();
        logic signed [stk_pkg::DATA_W-1:0] w;
        case ($urandom_range(0, 7))
            0: w = stk_pkg::WORD_MIN;
            1: w = WORD_MAX;
            2: w = stk_pkg::WORD_ONES;
            3: w = '0;
            4: w = stk_pkg::DATA_W'($urandom_range(0, 7));
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic stk_pkg::in_t random_command(int push_pct);
        stk_pkg::in_t t;
        int r;
        int hi;
        t.operand_value = random_word();
        t.depth_index = stk_pkg::DEPTH_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            t.cmd = stk_pkg::CMD_PUSH;
        end else if (r < push_pct + 3) begin
            t.cmd = 3'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
        end else begin
            case ($urandom_range(0, 3))
                0: t.cmd = stk_pkg::CMD_POP;
                1: t.cmd = stk_pkg::CMD_PEEK;
                2: t.cmd = stk_pkg::CMD_SEARCH;
                default: t.cmd = stk_pkg::CMD_MAX;
            endcase
        end
        if (t.cmd == stk_pkg::CMD_PEEK && $urandom_range(0, 3) != 0) begin
            hi = (shadow_count + 1 > DEPTH_LIMIT) ? DEPTH_LIMIT : shadow_count + 1;
            t.depth_index = stk_pkg::DEPTH_W'($urandom_range(0, hi));
        end
        if (t.cmd == stk_pkg::CMD_SEARCH && shadow_count > 0 && $urandom_range(0, 1) == 0)
            t.operand_value = shadow_mem[$urandom_range(0, shadow_count - 1)];
        return t;
    endfunction

    task automatic offer_command(stk_pkg::in_t item);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_stack_result(item));
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_and_extremes();
        logic [2:0] c;
        offer_command(make_command(stk_pkg::CMD_POP, '0, '0));
        offer_command(make_command(stk_pkg::CMD_PEEK, '0, '0));
        offer_command(make_command(stk_pkg::CMD_SEARCH, '0, '0));
        offer_command(make_command(stk_pkg::CMD_MAX, '0, '0));
        for (c = CMD_UNDEF_FIRST; c != stk_pkg::CMD_PUSH; c++)
            offer_command(make_command(c, stk_pkg::WORD_ONES, '1));
        offer_command(make_command(stk_pkg::CMD_PUSH, stk_pkg::WORD_MIN, '0));
        offer_command(make_command(stk_pkg::CMD_MAX, '0, '0));
        offer_command(make_command(stk_pkg::CMD_PUSH, WORD_MAX, '0));
        offer_command(make_command(stk_pkg::CMD_PUSH, stk_pkg::WORD_ONES, '0));
        offer_command(make_command(stk_pkg::CMD_PUSH, '0, '0));
        offer_command(make_command(stk_pkg::CMD_PUSH, stk_pkg::WORD_ONES, '0));
        offer_command(make_command(stk_pkg::CMD_PEEK, '0, 9'd0));
        offer_command(make_command(stk_pkg::CMD_PEEK, '0, 9'd1));
        offer_command(make_command(stk_pkg::CMD_PEEK, '0, 9'd5));
        offer_command(make_command(stk_pkg::CMD_PEEK, '0, 9'd6));
        offer_command(make_command(stk_pkg::CMD_PEEK, '0, '1));
        offer_command(make_command(stk_pkg::CMD_SEARCH, stk_pkg::WORD_ONES, '0));
        offer_command(make_command(stk_pkg::CMD_SEARCH, stk_pkg::WORD_MIN, '0));
        offer_command(make_command(stk_pkg::CMD_SEARCH, 32'sd42, '0));
        offer_command(make_command(stk_pkg::CMD_MAX, '0, '0));
        offer_command(make_command(CMD_UNDEF_LAST, '0, '0));
        repeat (6) offer_command(make_command(stk_pkg::CMD_POP, '0, '0));
    endtask

    task automatic test_fill_and_drain();
        logic signed [stk_pkg::DATA_W-1:0] bottom;
        bottom = random_word();
        offer_command(make_command(stk_pkg::CMD_PUSH, bottom, stk_pkg::DEPTH_W'($urandom)));
        repeat (stk_pkg::STACK_DEPTH - 1)
            offer_command(make_command(stk_pkg::CMD_PUSH, random_word(),
                                       stk_pkg::DEPTH_W'($urandom)));
        offer_command(make_command(stk_pkg::CMD_PUSH, random_word(), '0));
        offer_command(make_command(stk_pkg::CMD_PUSH, random_word(), '1));
        offer_command(make_command(stk_pkg::CMD_PEEK, '0,
                                   stk_pkg::DEPTH_W'(stk_pkg::STACK_DEPTH)));
        offer_command(make_command(stk_pkg::CMD_PEEK, '0,
                                   stk_pkg::DEPTH_W'(stk_pkg::STACK_DEPTH + 1)));
        offer_command(make_command(stk_pkg::CMD_PEEK, '0, '0));
        offer_command(make_command(stk_pkg::CMD_SEARCH, bottom, '0));
        offer_command(make_command(stk_pkg::CMD_SEARCH, $urandom, '0));
        offer_command(make_command(stk_pkg::CMD_MAX, '0, '0));
        repeat (stk_pkg::STACK_DEPTH + 1)
            offer_command(make_command(stk_pkg::CMD_POP, random_word(),
                                       stk_pkg::DEPTH_W'($urandom)));
    endtask

    task automatic test_random_mix();
        int seg;
        for (seg = 0; seg < 6; seg++)
            repeat (45) offer_command(random_command((seg % 2 == 0) ? 60 : 25));
    endtask

    task automatic test_receiver_hold();
        hold_req = 1'b1;
        repeat (12) offer_command(random_command(50));
    endtask

    task automatic test_steady_stream();
        repeat (100) offer_command(random_command(45));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall = 0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            rx_stall = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_stall = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no expectation pending");
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_data.status !== oldest_result.status) begin
                    $error("status: expected %0d, got %0d",
                           oldest_result.status, m_data.status);
                    mismatch_count++;
                end
                if (m_data.result_value !== oldest_result.result_value) begin
                    $error("result_value: expected %0d, got %0d",
                           oldest_result.result_value, m_data.result_value);
                    mismatch_count++;
                end
                if (m_data.found_depth !== oldest_result.found_depth) begin
                    $error("found_depth: expected %0d, got %0d",
                           oldest_result.found_depth, m_data.found_depth);
                    mismatch_count++;
                end
                if (m_data.is_empty !== oldest_result.is_empty) begin
                    $error("is_empty: expected %0d, got %0d",
                           oldest_result.is_empty, m_data.is_empty);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_extremes();
        wait_results();
        test_fill_and_drain();
        wait_results();
        test_random_mix();
        wait_results();
        test_receiver_hold();
        wait_results();
        idle_on = 1'b0;
        test_steady_stream();
        wait_results();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("stack_with_search_and_max regression: pass");
        end else begin
            $display("stack_with_search_and_max regression: fail");
        end
        $finish;
    end

    initial begin
        #(20 * 1500000);
        $display("stack_with_search_and_max regression: fail");
        $finish;
    end

endmodule
